/* sv/max_digit_rotation_unit_assert.svh */
// ----------------------------------------------------------------------------
// max_digit_rotation_unit_assert.svh
// Assertion macros used by the checker file mdr_checker.sv.
// ----------------------------------------------------------------------------
`ifndef MAX_DIGIT_ROTATION_UNIT_ASSERT_SVH
`define MAX_DIGIT_ROTATION_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MDR_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MDR_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/mdr_pkg.sv */
// ----------------------------------------------------------------------------
// mdr_pkg
// Shared constants, types and helpers of the max digit rotation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mdr_pkg;

  localparam int DIGIT_BITS = 2;
  localparam int MAX_DIGITS = 32;
  localparam int WORD_W     = 64;
  localparam int COUNT_W    = 6;

  // digits that fit in one word, and the usable digit limit
  localparam int FIT    = WORD_W / DIGIT_BITS;
  localparam int LIMIT  = (FIT < MAX_DIGITS) ? FIT : MAX_DIGITS;

  localparam int LANES  = (LIMIT < 4) ? LIMIT : 4;
  localparam int PASSES = (LIMIT + LANES - 1) / LANES;

  localparam int PASS_W  = (PASSES > 1) ? $clog2(PASSES) : 1;
  localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int ROT_W   = $clog2(PASSES * LANES + 1);
  localparam int N_W     = $clog2(LIMIT + 1);
  localparam int SHIFT_W = $clog2(WORD_W + 1);

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic              en;
    logic [PASS_W-1:0] pass;
  } lane_ctl_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } lane_res_t;

  // low nbits set; a full word gives all ones
  function automatic word_t used_mask(logic [SHIFT_W-1:0] nbits);
    word_t m;
    if (32'(nbits) >= WORD_W) begin
      m = '1;
    end else begin
      m = (word_t'(1) << nbits) - word_t'(1);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

/* sv/mdr_if.sv */
// ----------------------------------------------------------------------------
// mdr_if
// Valid/ready channels for input words and canonical results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mdr_word_if import mdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  digit_word;
  logic [COUNT_W-1:0] digit_count;

  modport source (output valid, output digit_word, output digit_count, input ready);
  modport sink   (input valid, input digit_word, input digit_count, output ready);
endinterface

interface mdr_result_if import mdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  canonical_word;
  logic [COUNT_W-1:0] canonical_count;

  modport source (output valid, output canonical_word, output canonical_count, input ready);
  modport sink   (input valid, input canonical_word, input canonical_count, output ready);
endinterface

`default_nettype wire

/* sv/max_digit_rotation_unit.sv */
// ----------------------------------------------------------------------------
// max_digit_rotation_unit
// Largest cyclic digit rotation of a packed word (canonical necklace form).
// ----------------------------------------------------------------------------
// Usage:
//   word_ch   : sink of digit_word/digit_count; a transfer happens when
//               valid and ready are both high at a rising clk edge.
//   result_ch : source of canonical_word/canonical_count, same handshake.
//   One word is in flight at a time. LANES rotation lanes each try one
//   rotation per cycle, so the LIMIT rotations are swept in PASSES =
//   LIMIT/LANES (rounded up) passes; one lane register stage and one
//   merge stage follow before the result enters the output register.
//   A new word is taken only once the previous result has left the merge
//   register. The result sits in an output register; the next word is
//   accepted while it waits. If the receiver stalls, the finished next
//   result is held in the merge register until the output register
//   frees up.
//   Reset (rst, synchronous) empties the pipeline and output register.
//   A count of zero returns the word unchanged; counts above LIMIT are
//   saturated for the search but echoed raw.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module max_digit_rotation_unit import mdr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  mdr_word_if.sink            word_ch,
  mdr_result_if.source        result_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t              state;
  logic [PASS_W-1:0]   pass;

  // captured item
  word_t               raw_word;
  word_t               cur;
  word_t               mask;
  logic [N_W-1:0]      n;
  logic [COUNT_W-1:0]  count;

  // output register
  logic                out_valid;
  word_t               out_word;
  logic [COUNT_W-1:0]  out_count;

  logic                accept;
  logic [N_W-1:0]      n_next;
  word_t               mask_next;
  lane_ctl_t           lane_ctl;
  lane_res_t           lane_res [LANES];
  word_t               best;
  logic                out_free;

  assign word_ch.ready = (state == S_IDLE) && !rst;
  assign accept        = word_ch.valid && word_ch.ready;
  assign out_free      = !out_valid || result_ch.ready;

  // saturate the count and build the used-digit mask at capture time
  always_comb begin
    n_next    = (32'(word_ch.digit_count) < LIMIT) ? N_W'(word_ch.digit_count)
                                                   : N_W'(LIMIT);
    mask_next = used_mask(SHIFT_W'(32'(n_next) * DIGIT_BITS));
  end

  assign lane_ctl.en   = (state == S_RUN);
  assign lane_ctl.pass = pass;

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    mdr_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (lane_ctl),
      .lane_id (LANE_W'(k)),
      .cur     (cur),
      .mask    (mask),
      .n       (n),
      .res     (lane_res[k])
    );
  end

  mdr_merge u_merge (
    .clk   (clk),
    .clear (accept),
    .lanes (lane_res),
    .best  (best)
  );

  // item capture (payload, no reset)
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_word <= word_ch.digit_word;
      cur      <= word_ch.digit_word & mask_next;
      mask     <= mask_next;
      n        <= n_next;
      count    <= word_ch.digit_count;
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pass      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RUN;
            pass  <= '0;
          end
        end
        S_RUN: begin
          if (pass == PASS_W'(PASSES - 1)) begin
            state <= S_DRAIN;
          end else begin
            pass <= pass + PASS_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_word  <= (n == '0) ? raw_word : best;
            out_count <= count;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result_ch.valid           = out_valid;
  assign result_ch.canonical_word  = out_word;
  assign result_ch.canonical_count = out_count;

endmodule

`default_nettype wire

/* sv/mdr_lane.sv */
// ----------------------------------------------------------------------------
// mdr_lane
// One rotation lane: rotates the masked word by pass*LANES+lane_id digits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdr_lane import mdr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  lane_ctl_t         ctl,
  input  logic [LANE_W-1:0] lane_id,
  input  word_t             cur,
  input  word_t             mask,
  input  logic [N_W-1:0]    n,
  output lane_res_t         res
);

  logic [ROT_W-1:0]   r;
  logic [SHIFT_W-1:0] shl;
  logic [SHIFT_W-1:0] shr;
  logic               hit;
  word_t              rot;

  always_comb begin
    r   = ROT_W'(ctl.pass) * ROT_W'(LANES) + ROT_W'(lane_id);
    hit = 32'(r) < 32'(n);
    // only meaningful when hit; r < n keeps both amounts within the word
    shl = SHIFT_W'(32'(r) * DIGIT_BITS);
    shr = SHIFT_W'((32'(n) - 32'(r)) * DIGIT_BITS);
    rot = ((cur << shl) | (cur >> shr)) & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res.valid <= ctl.en && hit;
    end
    res.word <= rot;
  end

endmodule

`default_nettype wire

/* sv/mdr_merge.sv */
// ----------------------------------------------------------------------------
// mdr_merge
// Folds the lane results of each pass into a running maximum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mdr_merge import mdr_pkg::*; (
  input  logic      clk,
  input  logic      clear,
  input  lane_res_t lanes [LANES],
  output word_t     best
);

  word_t cand;

  always_comb begin
    cand = best;
    for (int k = 0; k < LANES; k++) begin
      if (lanes[k].valid && (lanes[k].word > cand)) begin
        cand = lanes[k].word;
      end
    end
  end

  // every candidate is unsigned, so zero is a safe start value
  always_ff @(posedge clk) begin
    if (clear) begin
      best <= '0;
    end else begin
      best <= cand;
    end
  end

endmodule

`default_nettype wire

/* sv/mdr_checker.sv */
// ----------------------------------------------------------------------------
// mdr_checker
// Port-level assertions for max_digit_rotation_unit, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "max_digit_rotation_unit_assert.svh"

module mdr_checker import mdr_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic [COUNT_W-1:0] in_count,
  input logic               out_valid,
  input logic               out_ready,
  input logic [WORD_W-1:0]  out_word,
  input logic [COUNT_W-1:0] out_count
);

  logic [COUNT_W-1:0] last_count;
  logic [SHIFT_W-1:0] hi_shift;
  logic               in_xfer;

  assign in_xfer  = in_valid && in_ready && !rst;
  assign hi_shift = SHIFT_W'(32'(out_count) * DIGIT_BITS);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      last_count <= in_count;
    end
  end

  // one word in flight: no second transfer right after one
  `MDR_ASSERT_NEXT(a_one_in_flight, clk, rst, in_xfer, !in_ready, "ready after transfer")

  // a stalled result holds
  `MDR_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready,
                   out_valid && $stable(out_word) && $stable(out_count), "stalled result moved")

  // while idle, a waiting result belongs to the last word taken in
  `MDR_ASSERT_IMPL(a_count, clk, rst, out_valid && in_ready, out_count == last_count,
                   "count mismatch")

  // unsaturated nonzero count: bits above the used digits are clear
  `MDR_ASSERT_IMPL(a_masked, clk, rst,
                   out_valid && (out_count != '0) && (32'(out_count) < LIMIT),
                   (out_word >> hi_shift) == '0, "bits above used digits")

endmodule

bind max_digit_rotation_unit mdr_checker u_mdr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (word_ch.valid),
  .in_ready  (word_ch.ready),
  .in_count  (word_ch.digit_count),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .out_word  (result_ch.canonical_word),
  .out_count (result_ch.canonical_count)
);

`default_nettype wire

/* tb/max_digit_rotation_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_digit_rotation_checker
// Watches both channels of the rotation unit. Every word transfer is turned
// into the expected canonical rotation. Every result transfer is compared
// with the oldest expectation. Mismatches and the number of results still
// outstanding are passed up to the bench top.
// ----------------------------------------------------------------------------
module max_digit_rotation_checker import mdr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  mdr_word_if   word_ch,
  mdr_result_if result_ch,
  output int    mismatch_count,
  output int    pending
);

  typedef struct packed {
    word_t              word;
    logic [COUNT_W-1:0] count;
  } canonical_t;

  canonical_t canonical_q[$];

  // Largest rotation of the used digits. Counts past LIMIT saturate.
  // A zero count passes the word through untouched.
  function automatic word_t max_rotation(word_t w, logic [COUNT_W-1:0] cnt);
    int    n;
    int    i;
    word_t mask;
    word_t cur;
    word_t best;
    word_t up;
    word_t wrap;
    n = (int'(cnt) < LIMIT) ? int'(cnt) : LIMIT;
    if (n == 0) begin
      return w;
    end
    if (n * DIGIT_BITS >= WORD_W) begin
      mask = '1;
    end else begin
      mask = (word_t'(1) << (n * DIGIT_BITS)) - word_t'(1);
    end
    cur  = w & mask;
    best = cur;
    for (i = 0; i < n; i++) begin
      up   = (DIGIT_BITS >= WORD_W) ? '0 : ((cur << DIGIT_BITS) & mask);
      wrap = cur >> ((n - 1) * DIGIT_BITS);
      cur  = (up | wrap) & mask;
      if (cur > best) begin
        best = cur;
      end
    end
    return best;
  endfunction

  always @(posedge clk) begin
    canonical_t exp_r;
    int         errs;
    if (rst) begin
      canonical_q.delete();
      mismatch_count <= 0;
      pending        <= 0;
    end else begin
      errs = 0;
      // compare before push: a result can never belong to a same-edge word
      if (result_ch.valid && result_ch.ready) begin
        if (canonical_q.size() == 0) begin
          $error("unexpected result: canonical_word=%h canonical_count=%0d",
                 result_ch.canonical_word, result_ch.canonical_count);
          errs++;
        end else begin
          exp_r = canonical_q.pop_front();
          if (result_ch.canonical_word !== exp_r.word) begin
            $error("canonical_word: expected %h, actual %h",
                   exp_r.word, result_ch.canonical_word);
            errs++;
          end
          if (result_ch.canonical_count !== exp_r.count) begin
            $error("canonical_count: expected %0d, actual %0d",
                   exp_r.count, result_ch.canonical_count);
            errs++;
          end
        end
      end
      if (word_ch.valid && word_ch.ready) begin
        canonical_q.push_back({max_rotation(word_ch.digit_word, word_ch.digit_count),
                               word_ch.digit_count});
      end
      mismatch_count <= mismatch_count + errs;
      pending        <= canonical_q.size();
    end
  end

endmodule

/* tb/max_digit_rotation_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_digit_rotation_unit_tb
// Bench top for the max digit rotation unit. Drives a directed set of words
// (zero count, full width, oversized counts, masked high digits), then about
// 1250 random words with random source gaps and sink stalls. The checker
// beside the block predicts each canonical rotation and compares results.
// ----------------------------------------------------------------------------
module max_digit_rotation_unit_tb;
  import mdr_pkg::*;

  // Worst case per word is the issue interval plus source gap and sink
  // stall; this limit leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = PASSES + 12;
  localparam int RANDOM_WORDS  = 1250;
  localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // when set, neither side inserts idle cycles
  bit steady = 1'b0;

  int          mismatch_count;
  int          pending;
  int unsigned cycle_count = 0;

  mdr_word_if   word_ch ();
  mdr_result_if result_ch ();

  max_digit_rotation_unit uut (
    .clk       (clk),
    .rst       (rst),
    .word_ch   (word_ch),
    .result_ch (result_ch)
  );

  max_digit_rotation_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .word_ch        (word_ch),
    .result_ch      (result_ch),
    .mismatch_count (mismatch_count),
    .pending        (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop if the pipeline ever wedges.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // One word transfer, after a random gap with valid low.
  // Valid is only dropped when a gap is drawn, so back-to-back transfers
  // keep it high without a low/high pair in the same step.
  task automatic send_word(input word_t w, input logic [COUNT_W-1:0] c);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      word_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_ch.valid       <= 1'b1;
    word_ch.digit_word  <= w;
    word_ch.digit_count <= c;
    @(posedge clk);
    while (!word_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait for every expected result. The first edge lets
  // the checker's count catch up with the last transfer.
  task automatic drain();
    word_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Random word, biased toward shapes that stress the compare: periodic
  // necklaces (tied rotations), sparse words, near-all-ones words.
  function automatic word_t necklace_word();
    int    kind;
    int    period;
    int    i;
    word_t pat;
    word_t w;
    kind = $urandom_range(0, 9);
    w    = {$urandom, $urandom};
    case (kind)
      5, 6: begin
        period = $urandom_range(1, 8) * DIGIT_BITS;
        pat    = {$urandom, $urandom} & ((word_t'(1) << period) - word_t'(1));
        w      = '0;
        for (i = 0; i < WORD_W; i += period) begin
          w |= pat << i;
        end
      end
      7: begin
        w = '0;
        w[$urandom_range(0, WORD_W - 1)] = 1'b1;
        w[$urandom_range(0, WORD_W - 1)] = 1'b1;
      end
      8: begin
        w = '1;
        w[$urandom_range(0, WORD_W - 1)] = 1'b0;
      end
      9: begin
        w = w & {$urandom, $urandom} & {$urandom, $urandom};
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  // Mostly legal counts with small ones favored; a slice above LIMIT
  // exercises saturation and the upper count bits.
  function automatic logic [COUNT_W-1:0] random_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return COUNT_W'(LIMIT);
    end else if (r <= 3) begin
      return COUNT_W'($urandom_range(LIMIT + 1, COUNT_TOP));
    end else if (r <= 8) begin
      return COUNT_W'($urandom_range(1, 4));
    end
    return COUNT_W'($urandom_range(1, LIMIT));
  endfunction

  // Sink side: random stall before each result, released once it transfers.
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // Source side: reset, directed words, random words, verdict.
  initial begin
    int k;
    word_ch.valid       <= 1'b0;
    word_ch.digit_word  <= '0;
    word_ch.digit_count <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero count: word comes back as is, high bits included
    send_word('1, 6'd0);
    send_word(64'hDEAD_BEEF_0123_4567, 6'd0);
    // full width: mask is all ones
    send_word('1, 6'd32);
    send_word('0, 6'd32);
    send_word(64'h0000_0000_0000_0001, 6'd32);
    send_word(64'h8000_0000_0000_0000, 6'd32);
    send_word(64'hC000_0000_0000_0003, 6'd32);
    send_word(64'hFFFF_FFFF_0000_0000, 6'd32);
    send_word(64'h5555_5555_5555_5555, 6'd32);
    // single digit, junk above it must be masked off
    send_word(64'hFFFF_FFFF_FFFF_FFF2, 6'd1);
    // partial counts, some with bits set above the used digits
    send_word(64'hFFFF_FFFF_FFFF_FF06, 6'd2);
    send_word(64'h0000_0000_0000_003F, 6'd3);
    send_word(64'h0000_0000_0000_001B, 6'd4);
    send_word(64'h0123_4567_89AB_CDEF, 6'd31);
    send_word(64'hAAAA_AAAA_AAAA_AAAA, 6'd17);
    send_word(64'h0000_0000_0000_0001, 6'd16);
    // counts past the limit saturate but echo raw
    send_word(64'h0000_0000_0000_0007, 6'd33);
    send_word(64'h1234_5678_9ABC_DEF0, 6'd40);
    send_word({$urandom, $urandom}, 6'd48);
    send_word({$urandom, $urandom}, COUNT_TOP);

    // hold off until everything directed has come back
    drain();

    for (k = 0; k < RANDOM_WORDS; k++) begin
      // alternate stretches with and without idle cycles
      if (k % 100 == 0) begin
        steady = ($urandom_range(0, 3) == 0);
      end
      if (k == RANDOM_WORDS / 2) begin
        drain();
      end
      send_word(necklace_word(), random_count());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* max_digit_rotation_unit.f */
+incdir+sv
sv/mdr_pkg.sv
sv/mdr_if.sv
sv/mdr_lane.sv
sv/mdr_merge.sv
sv/max_digit_rotation_unit.sv
sv/mdr_checker.sv
tb/max_digit_rotation_checker.sv
tb/max_digit_rotation_unit_tb.sv
